// ----- hw/rtl/mpwm_pkg.sv -----
// Package for the motor PWM drive with start boost.
// Holds field widths, duty limits, the hold reset value, register indexes, bridge wirings and the result record.
// No dependencies.
`default_nettype none

package mpwm_pkg;

    // Field widths
    localparam int SPEED_W = 8;
    localparam int DUTY_W  = 7;
    localparam int TICK_W  = 32;
    localparam int HOLD_W  = 16;
    localparam int IDX_W   = 2;

    // Duty limits and the hold register reset value
    localparam logic signed [SPEED_W-1:0] FULL_DUTY_S = 8'sd100;
    localparam logic signed [SPEED_W-1:0] NEG_DUTY_S  = -8'sd100;
    localparam logic [DUTY_W-1:0]         FULL_DUTY   = 7'd100;
    localparam logic [HOLD_W-1:0]         HOLD_RESET  = 16'd300;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_BRIDGE_TYPE = 2'd0;
    localparam logic [IDX_W-1:0] REG_INVERT_DIR  = 2'd1;
    localparam logic [IDX_W-1:0] REG_BOOST_HOLD  = 2'd2;

    // Bridge wirings
    localparam logic BRIDGE_PWM_DIR = 1'b0;
    localparam logic BRIDGE_TWO_PWM = 1'b1;

    // One result record
    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic              reverse_pin;
        logic              cmd_ignored;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/motor_pwm_drive_with_start_boost.sv -----
// Motor PWM drive with start boost: top level, single module.
// Uses mpwm_pkg for widths, limits, register indexes and the result record.
// Holds the drive state, the boost timer and a two-entry result buffer.
//
// Each accepted speed request gives exactly one result. A new request can be
// taken every cycle while the skid slot is empty, so the sustained rate is one
// request per clock while m_tready stays high. The whole decision (clamp, boost
// start, hold expiry by a 32-bit tick subtract and compare, bridge mapping) is
// combinational between the request port and the result register. A second
// result slot lets a request be taken while one result still waits downstream;
// s_tready falls only when both slots are full. Configuration writes are
// registered and belong in idle periods. There is no clearing pass after reset.
`default_nettype none

module motor_pwm_drive_with_start_boost
    import mpwm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Request side
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire logic [47:0]       s_tdata,   // speed_cmd[7:0], boost_level[14:8],
                                              // now_tick[46:15], zero pad[47]
    // Result side
    output      logic              m_tvalid,
    input  wire logic              m_tready,
    output      logic [15:0]       m_tdata,   // duty_a[6:0], duty_b[13:7],
                                              // reverse_pin[14], zero pad[15]
    output      logic              m_tuser,   // cmd_ignored
    // Configuration write port
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_addr,
    input  wire logic [HOLD_W-1:0] cfg_wdata
);

    // Configuration registers
    logic              bridge_type_reg;
    logic              invert_dir_reg;
    logic [HOLD_W-1:0] hold_ticks_reg;

    // Drive state
    logic              stopped_reg;
    logic              boost_active_reg;
    logic [TICK_W-1:0] boost_start_reg;
    logic [DUTY_W-1:0] duty_a_reg;
    logic [DUTY_W-1:0] duty_b_reg;
    logic              reverse_reg;

    // Result buffer
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic              skid_valid_reg;
    result_t           skid_res_reg;

    // Request fields
    logic signed [SPEED_W-1:0] speed_cmd;
    logic [DUTY_W-1:0]         boost_level;
    logic [TICK_W-1:0]         now_tick;

    // Datapath
    logic                      accept;
    logic signed [SPEED_W-1:0] drive;
    logic [DUTY_W-1:0]         kick;
    logic [TICK_W-1:0]         elapsed;
    logic                      hold_expired;
    logic                      ignored;
    logic                      boost_start;
    logic signed [SPEED_W-1:0] drive_boost;
    logic signed [SPEED_W-1:0] drive_final;
    logic [SPEED_W-1:0]        drive_mag;
    logic [DUTY_W-1:0]         duty_a_next;
    logic [DUTY_W-1:0]         duty_b_next;
    logic                      reverse_next;
    result_t                   res;

    assign speed_cmd   = signed'(s_tdata[7:0]);
    assign boost_level = s_tdata[14:8];
    assign now_tick    = s_tdata[46:15];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Clamp command and kick, check the hold window
    always_comb
    begin
        if (speed_cmd > FULL_DUTY_S)
            drive = FULL_DUTY_S;
        else if (speed_cmd < NEG_DUTY_S)
            drive = NEG_DUTY_S;
        else
            drive = speed_cmd;

        kick = (boost_level > FULL_DUTY) ? FULL_DUTY : boost_level;

        elapsed      = now_tick - boost_start_reg;
        hold_expired = (elapsed >= {{(TICK_W-HOLD_W){1'b0}}, hold_ticks_reg});
        ignored      = boost_active_reg && !hold_expired;
    end

    // Start boost, apply inversion and map onto the bridge
    always_comb
    begin
        boost_start = (kick != '0) && stopped_reg && (drive != '0);

        if (boost_start)
            drive_boost = (drive > 0) ? signed'({1'b0, kick}) : -signed'({1'b0, kick});
        else
            drive_boost = drive;

        drive_final = invert_dir_reg ? -drive_boost : drive_boost;
        drive_mag   = (drive_final < 0) ? unsigned'(-drive_final) : unsigned'(drive_final);

        duty_a_next  = duty_a_reg;
        duty_b_next  = duty_b_reg;
        reverse_next = reverse_reg;
        if (!ignored)
        begin
            case (bridge_type_reg)
                BRIDGE_PWM_DIR:
                begin
                    if (drive_final == '0)
                    begin
                        duty_a_next  = '0;
                        duty_b_next  = '0;
                        reverse_next = 1'b0;
                    end
                    else if (drive_final > 0)
                    begin
                        duty_a_next  = drive_mag[DUTY_W-1:0];
                        duty_b_next  = FULL_DUTY;
                        reverse_next = 1'b0;
                    end
                    else
                    begin
                        duty_a_next  = drive_mag[DUTY_W-1:0];
                        duty_b_next  = '0;
                        reverse_next = 1'b1;
                    end
                end
                BRIDGE_TWO_PWM:
                begin
                    if (drive_final == '0)
                    begin
                        duty_a_next = '0;
                        duty_b_next = '0;
                    end
                    else if (drive_final > 0)
                    begin
                        duty_a_next = drive_mag[DUTY_W-1:0];
                        duty_b_next = '0;
                    end
                    else
                    begin
                        duty_a_next = '0;
                        duty_b_next = drive_mag[DUTY_W-1:0];
                    end
                end
                default:
                begin
                    duty_a_next  = duty_a_reg;
                    duty_b_next  = duty_b_reg;
                    reverse_next = reverse_reg;
                end
            endcase
        end

        res.duty_a      = duty_a_next;
        res.duty_b      = duty_b_next;
        res.reverse_pin = reverse_next;
        res.cmd_ignored = ignored;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_type_reg <= 1'b0;
            invert_dir_reg  <= 1'b0;
            hold_ticks_reg  <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BRIDGE_TYPE: bridge_type_reg <= cfg_wdata[0];
                REG_INVERT_DIR:  invert_dir_reg  <= cfg_wdata[0];
                REG_BOOST_HOLD:  hold_ticks_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Advance the drive state on each accepted request that is not ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg      <= 1'b1;
            boost_active_reg <= 1'b0;
            boost_start_reg  <= '0;
            duty_a_reg       <= '0;
            duty_b_reg       <= '0;
            reverse_reg      <= 1'b0;
        end
        else if (accept && !ignored)
        begin
            stopped_reg      <= (drive_final == '0);
            boost_active_reg <= boost_start;
            if (boost_start)
                boost_start_reg <= now_tick;
            duty_a_reg  <= duty_a_next;
            duty_b_reg  <= duty_b_next;
            reverse_reg <= reverse_next;
        end
    end

    // Result buffer: main slot plus skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && m_tready)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else if (!accept)
                out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    // Payload of the result buffer
    always_ff @(posedge clk)
    begin
        if (out_valid_reg && m_tready)
        begin
            if (skid_valid_reg)
                out_res_reg <= skid_res_reg;
            else if (accept)
                out_res_reg <= res;
        end
        else if (accept)
        begin
            if (!out_valid_reg)
                out_res_reg <= res;
            else
                skid_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.reverse_pin, out_res_reg.duty_b, out_res_reg.duty_a};
    assign m_tuser  = out_res_reg.cmd_ignored;

    // Checks
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while main slot empty");

    a_ignored_keeps_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ignored) |=> boost_active_reg)
        else $error("boost hold dropped on an ignored request");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (res.duty_a <= FULL_DUTY && res.duty_b <= FULL_DUTY))
        else $error("duty beyond full scale");

    a_two_pwm_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !ignored && bridge_type_reg == BRIDGE_TWO_PWM)
            |-> (res.duty_a == '0 || res.duty_b == '0))
        else $error("both bridge legs driven on two-PWM wiring");

endmodule

`default_nettype wire
